[design/vn_pkg.sv]
package vn_pkg;

    localparam int COMPONENT_WIDTH_DEF = 32;
    localparam int UNIT_W = 32;
    localparam int LEN_W = 33;
    localparam int TOL_W = 16;
    localparam int FRAC_SHIFT = 14;
    localparam int UNIT_SHIFT = 30;
    localparam int QUOT_W = UNIT_SHIFT + 1;
    localparam logic [TOL_W-1:0] TOL_RESET = 16'd7;
    localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

endpackage

[design/vn_sqrt_cell.sv]
module vn_sqrt_cell #(
    parameter int SW = 64,
    parameter int LB = 32,
    parameter int AW = 99,
    parameter int BIT = 0
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          in_valid,
    input  logic [SW-1:0] in_rem,
    input  logic [LB-1:0] in_root,
    input  logic [AW-1:0] in_aux,
    output logic          out_valid,
    output logic [SW-1:0] out_rem,
    output logic [LB-1:0] out_root,
    output logic [AW-1:0] out_aux
);

    logic [SW-1:0] trial;
    logic          take;
    logic          valid_reg;
    logic [SW-1:0] rem_reg, rem_next;
    logic [LB-1:0] root_reg, root_next;
    logic [AW-1:0] aux_reg;

    always_comb begin
        trial     = (SW'(in_root) << (BIT + 1)) | (SW'(1) << (2 * BIT));
        take      = in_rem >= trial;
        rem_next  = take ? in_rem - trial : in_rem;
        root_next = take ? (in_root | (LB'(1) << BIT)) : in_root;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
        if (en) begin
            rem_reg  <= rem_next;
            root_reg <= root_next;
            aux_reg  <= in_aux;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_root  = root_reg;
    assign out_aux   = aux_reg;

endmodule

[design/vn_div_cell.sv]
module vn_div_cell #(
    parameter int LB = 32,
    parameter int AW = 34,
    parameter bit FIRST = 1'b0
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      en,
    input  logic                      in_valid,
    input  logic [LB:0]               in_r,
    input  logic [vn_pkg::QUOT_W-1:0] in_q,
    input  logic [LB-1:0]             in_d,
    input  logic [AW-1:0]             in_aux,
    output logic                      out_valid,
    output logic [LB:0]               out_r,
    output logic [vn_pkg::QUOT_W-1:0] out_q,
    output logic [LB-1:0]             out_d,
    output logic [AW-1:0]             out_aux
);

    logic [LB:0]               rr;
    logic                      ge;
    logic                      valid_reg;
    logic [LB:0]               r_reg, r_next;
    logic [vn_pkg::QUOT_W-1:0] q_reg, q_next;
    logic [LB-1:0]             d_reg;
    logic [AW-1:0]             aux_reg;

    always_comb begin
        rr     = FIRST ? in_r : (in_r << 1);
        ge     = rr >= {1'b0, in_d};
        r_next = ge ? rr - {1'b0, in_d} : rr;
        q_next = FIRST ? vn_pkg::QUOT_W'(ge) : ((in_q << 1) | vn_pkg::QUOT_W'(ge));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
        if (en) begin
            r_reg   <= r_next;
            q_reg   <= q_next;
            d_reg   <= in_d;
            aux_reg <= in_aux;
        end
    end

    assign out_valid = valid_reg;
    assign out_r     = r_reg;
    assign out_q     = q_reg;
    assign out_d     = d_reg;
    assign out_aux   = aux_reg;

endmodule

[design/vector3_normalize_top.sv]
// A word passes input registers, square-root cells, divider cells and the output register.
// Throughput: one vector per cycle unless the output stalls; the cell rows advance together.
// A stalled output holds the whole pipeline in place.
// Reset (aresetn low, synchronous) empties the pipeline and sets the tolerance to 7.
module vector3_normalize_top #(
    parameter int COMPONENT_WIDTH = vn_pkg::COMPONENT_WIDTH_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // vec_x, vec_y, vec_z, zero padding
    input  logic [((3*COMPONENT_WIDTH+7)/8)*8-1:0] s_tdata,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // unit_x, unit_y, unit_z, length, zero padding
    output logic [((3*vn_pkg::UNIT_W+vn_pkg::LEN_W+7)/8)*8-1:0] m_tdata,
    // tiny_input
    output logic [0:0]                   m_tuser,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [vn_pkg::TOL_W-1:0]     cfg_data
);

    localparam int CW = COMPONENT_WIDTH;
    localparam int SW = 2 * CW;
    localparam int LB = CW;
    localparam int SQ_AW = 3 * CW + 3;
    localparam int DV_AW = CW + 2;
    localparam int NDIV = vn_pkg::QUOT_W;
    localparam int XW = (LB > vn_pkg::LEN_W) ? LB : vn_pkg::LEN_W;
    localparam int OUT_W = ((3 * vn_pkg::UNIT_W + vn_pkg::LEN_W + 7) / 8) * 8;

    logic                     en;
    logic [vn_pkg::TOL_W-1:0] tol_reg;

    logic                 v0_reg, v1_reg, v2_reg;
    logic [CW-1:0]        mag0_reg [3];
    logic [2:0]           neg0_reg, neg1_reg, neg2_reg;
    logic [CW-1:0]        mag1_reg [3];
    logic [CW-1:0]        mag2_reg [3];
    logic [SW-1:0]        sq1_reg [3];
    logic [SW-1:0]        sum2_reg;

    logic                 sq_valid [LB+1];
    logic [SW-1:0]        sq_rem [LB+1];
    logic [LB-1:0]        sq_root [LB+1];
    logic [SQ_AW-1:0]     sq_aux [LB+1];

    logic                 tiny_in;
    logic [XW-1:0]        len_x;

    logic                       dv_valid [3][NDIV+1];
    logic [LB:0]                dv_r [3][NDIV+1];
    logic [vn_pkg::QUOT_W-1:0]  dv_q [3][NDIV+1];
    logic [LB-1:0]              dv_d [3][NDIV+1];
    logic [DV_AW-1:0]           dv_aux [3][NDIV+1];

    logic                      m_tvalid_reg;
    logic [vn_pkg::UNIT_W-1:0] unit_reg [3];
    logic [vn_pkg::UNIT_W-1:0] unit_next [3];
    logic [vn_pkg::LEN_W-1:0]  len_reg, len_next;
    logic                      tiny_reg;
    logic [XW-1:0]             len_end;

    assign en        = !m_tvalid_reg || m_tready;
    assign s_tready  = en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tol_reg <= vn_pkg::TOL_RESET;
        end else if (cfg_valid) begin
            tol_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (en) begin
            v0_reg <= s_tvalid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
        end
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                neg0_reg[i] <= s_tdata[i*CW + CW - 1];
                mag0_reg[i] <= s_tdata[i*CW + CW - 1] ? CW'(-s_tdata[i*CW +: CW])
                                                     : s_tdata[i*CW +: CW];
                sq1_reg[i]  <= SW'(mag0_reg[i]) * SW'(mag0_reg[i]);
                mag1_reg[i] <= mag0_reg[i];
                mag2_reg[i] <= mag1_reg[i];
            end
            neg1_reg <= neg0_reg;
            neg2_reg <= neg1_reg;
            sum2_reg <= sq1_reg[0] + sq1_reg[1] + sq1_reg[2];
        end
    end

    assign sq_valid[0] = v2_reg;
    assign sq_rem[0]   = sum2_reg;
    assign sq_root[0]  = '0;
    assign sq_aux[0]   = {neg2_reg, mag2_reg[2], mag2_reg[1], mag2_reg[0]};

    for (genvar k = 0; k < LB; k++) begin : g_sqrt
        vn_sqrt_cell #(.SW(SW), .LB(LB), .AW(SQ_AW), .BIT(LB - 1 - k)) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (sq_valid[k]),
            .in_rem    (sq_rem[k]),
            .in_root   (sq_root[k]),
            .in_aux    (sq_aux[k]),
            .out_valid (sq_valid[k+1]),
            .out_rem   (sq_rem[k+1]),
            .out_root  (sq_root[k+1]),
            .out_aux   (sq_aux[k+1])
        );
    end

    assign len_x   = XW'(sq_root[LB]);
    assign tiny_in = len_x <= XW'(tol_reg);

    for (genvar l = 0; l < 3; l++) begin : g_lane
        assign dv_valid[l][0] = sq_valid[LB];
        assign dv_r[l][0]     = {1'b0, sq_aux[LB][l*CW +: CW]};
        assign dv_q[l][0]     = '0;
        assign dv_d[l][0]     = sq_root[LB];
        assign dv_aux[l][0]   = {tiny_in, sq_aux[LB][3*CW + l], sq_aux[LB][l*CW +: CW]};

        for (genvar k = 0; k < NDIV; k++) begin : g_div
            vn_div_cell #(.LB(LB), .AW(DV_AW), .FIRST(k == 0)) u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .en        (en),
                .in_valid  (dv_valid[l][k]),
                .in_r      (dv_r[l][k]),
                .in_q      (dv_q[l][k]),
                .in_d      (dv_d[l][k]),
                .in_aux    (dv_aux[l][k]),
                .out_valid (dv_valid[l][k+1]),
                .out_r     (dv_r[l][k+1]),
                .out_q     (dv_q[l][k+1]),
                .out_d     (dv_d[l][k+1]),
                .out_aux   (dv_aux[l][k+1])
            );
        end
    end

    always_comb begin
        logic [vn_pkg::UNIT_W-1:0] qs;
        logic [vn_pkg::UNIT_W-1:0] flush;
        flush = vn_pkg::UNIT_W'({tol_reg, {vn_pkg::FRAC_SHIFT{1'b0}}});
        for (int l = 0; l < 3; l++) begin
            qs = dv_aux[l][NDIV][CW+1]
                 ? (vn_pkg::UNIT_W'(dv_aux[l][NDIV][CW-1:0]) << vn_pkg::FRAC_SHIFT)
                 : vn_pkg::UNIT_W'(dv_q[l][NDIV]);
            if (qs < flush) begin
                qs = '0;
            end
            unit_next[l] = dv_aux[l][NDIV][CW] ? -qs : qs;
        end
        len_end  = XW'(dv_d[0][NDIV]);
        len_next = (len_end > XW'(vn_pkg::LEN_MAX)) ? vn_pkg::LEN_MAX
                                                    : len_end[vn_pkg::LEN_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= dv_valid[0][NDIV] & dv_valid[1][NDIV] & dv_valid[2][NDIV];
        end
        if (en) begin
            for (int l = 0; l < 3; l++) begin
                unit_reg[l] <= unit_next[l];
            end
            len_reg  <= len_next;
            tiny_reg <= dv_aux[0][NDIV][CW+1];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = OUT_W'({len_reg, unit_reg[2], unit_reg[1], unit_reg[0]});
    assign m_tuser  = tiny_reg;

`ifndef NO_ASSERTIONS
    a_tiny_short: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> len_reg < vn_pkg::LEN_W'(1 << vn_pkg::TOL_W))
        else $error("tiny result with a long vector");
    a_unit_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($signed(unit_reg[0]) <= $signed(32'sd1073741824)
                  && $signed(unit_reg[0]) >= $signed(-32'sd1073741824)))
        else $error("unit component out of range");
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(sq_valid[LB]) && $stable(sum2_reg))
        else $error("pipeline moved during stall");
`endif

endmodule
